// File: design/ptsd_pkg.sv
// Shared widths, region codes and inter-stage word types for the point to
// segment distance pipeline. No dependencies.
package ptsd_pkg;

    localparam int CoordW = 16;                 // Q12.4 coordinate width
    localparam int DiffW  = CoordW + 1;         // coordinate difference
    localparam int ProdW  = 2 * DiffW;          // product of two differences
    localparam int SumW   = ProdW + 1;          // signed sum of two products
    localparam int ValW   = ProdW;              // unsigned squared distance
    localparam int HalfW  = ValW / 2;           // split of the cross magnitude
    localparam int NumW   = 2 * ValW - 1;       // cross squared
    localparam int RootW  = ValW / 2;           // square root width
    localparam int DistW  = 17;                 // distance field width
    localparam int DivSteps  = ValW;
    localparam int RootSteps = RootW;

    localparam logic [1:0] RegionStart    = 2'd0;
    localparam logic [1:0] RegionInterior = 2'd1;
    localparam logic [1:0] RegionEnd      = 2'd2;

    typedef struct packed {
        logic signed [CoordW-1:0] ey;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] px;
    } t_coords;

    typedef struct packed {
        logic [1:0]      region;
        logic [NumW-1:0] num;
        logic [ValW-1:0] den;
    } t_div_word;

    typedef struct packed {
        logic [1:0]      region;
        logic [ValW-1:0] val;
    } t_root_word;

endpackage

// File: design/ptsd_front.sv
// Front end: differences, products, projection test and cross squared.
// Six register stages; depends on ptsd_pkg.
module ptsd_front import ptsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_vld,
    output logic      o_rdy,
    input  t_coords   i_pts,
    output logic      o_vld,
    input  logic      i_rdy,
    output t_div_word o_word
);
    logic [5:0] r_v;
    logic [6:0] en;

    logic signed [DiffW-1:0] r1_a, r1_b, r1_c, r1_d, r1_fx, r1_fy;
    logic signed [ProdW-1:0] r2_ac, r2_bd, r2_cc, r2_dd, r2_aa, r2_bb;
    logic signed [ProdW-1:0] r2_fxx, r2_fyy, r2_ad, r2_bc;
    logic signed [SumW-1:0]  r3_dot, r3_cross;
    logic [ValW-1:0]         r3_len, r3_sq0, r3_sq2;
    logic [1:0]              r4_region, r5_region, r6_region;
    logic [ValW-1:0]         r4_v, r4_cr, r4_len, r5_v, r5_len;
    logic [ValW-1:0]         r5_hh, r5_hl, r5_ll;
    logic [NumW-1:0]         r6_num;
    logic [ValW-1:0]         r6_den;
    logic [1:0]              n4_region;
    logic [ValW-1:0]         cr_hi, cr_lo;

    always_comb begin
        en[6] = i_rdy;
        for (int i = 5; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end
    assign o_rdy = en[0];

    always_comb begin
        if (r3_len == '0 || r3_dot < 0) begin
            n4_region = RegionStart;
        end else if (r3_dot > $signed({1'b0, r3_len})) begin
            n4_region = RegionEnd;
        end else begin
            n4_region = RegionInterior;
        end
    end

    // halves of the cross magnitude, widened so the products keep every bit
    assign cr_hi = ValW'(r4_cr[ValW-1:HalfW]);
    assign cr_lo = ValW'(r4_cr[HalfW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < 6; i++) begin
                if (en[i]) begin
                    r_v[i] <= (i == 0) ? i_vld : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_a  <= DiffW'(i_pts.px) - DiffW'(i_pts.sx);
            r1_b  <= DiffW'(i_pts.py) - DiffW'(i_pts.sy);
            r1_c  <= DiffW'(i_pts.ex) - DiffW'(i_pts.sx);
            r1_d  <= DiffW'(i_pts.ey) - DiffW'(i_pts.sy);
            r1_fx <= DiffW'(i_pts.px) - DiffW'(i_pts.ex);
            r1_fy <= DiffW'(i_pts.py) - DiffW'(i_pts.ey);
        end
        if (en[1]) begin
            r2_ac  <= r1_a * r1_c;
            r2_bd  <= r1_b * r1_d;
            r2_cc  <= r1_c * r1_c;
            r2_dd  <= r1_d * r1_d;
            r2_aa  <= r1_a * r1_a;
            r2_bb  <= r1_b * r1_b;
            r2_fxx <= r1_fx * r1_fx;
            r2_fyy <= r1_fy * r1_fy;
            r2_ad  <= r1_a * r1_d;
            r2_bc  <= r1_b * r1_c;
        end
        if (en[2]) begin
            r3_dot   <= SumW'(r2_ac) + SumW'(r2_bd);
            r3_cross <= SumW'(r2_ad) - SumW'(r2_bc);
            r3_len   <= $unsigned(r2_cc) + $unsigned(r2_dd);
            r3_sq0   <= $unsigned(r2_aa) + $unsigned(r2_bb);
            r3_sq2   <= $unsigned(r2_fxx) + $unsigned(r2_fyy);
        end
        if (en[3]) begin
            r4_region <= n4_region;
            r4_v      <= (n4_region == RegionEnd) ? r3_sq2 : r3_sq0;
            r4_cr     <= (r3_cross < 0) ? ValW'(-r3_cross) : ValW'(r3_cross);
            r4_len    <= r3_len;
        end
        if (en[4]) begin
            // split the cross magnitude so each multiplier stays narrow
            r5_hh     <= cr_hi * cr_hi;
            r5_hl     <= cr_hi * cr_lo;
            r5_ll     <= cr_lo * cr_lo;
            r5_region <= r4_region;
            r5_v      <= r4_v;
            r5_len    <= r4_len;
        end
        if (en[5]) begin
            r6_region <= r5_region;
            if (r5_region == RegionInterior) begin
                r6_num <= (NumW'(r5_hh) << (2 * HalfW)) + (NumW'(r5_hl) << (HalfW + 1))
                        + NumW'(r5_ll);
                r6_den <= r5_len;
            end else begin
                // plain squared distance: divide by one
                r6_num <= NumW'(r5_v);
                r6_den <= ValW'(1);
            end
        end
    end

    assign o_vld         = r_v[5];
    assign o_word.region = r6_region;
    assign o_word.num    = r6_num;
    assign o_word.den    = r6_den;
endmodule

// File: design/ptsd_div.sv
// Restoring divider, one quotient bit per register stage.
// Depends on ptsd_pkg.
module ptsd_div import ptsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    output logic       o_rdy,
    input  t_div_word  i_word,
    output logic       o_vld,
    input  logic       i_rdy,
    output t_root_word o_word
);
    logic [DivSteps-1:0] r_v;
    logic [DivSteps:0]   en;
    logic [ValW-1:0]     r_rem [DivSteps];
    logic [ValW-1:0]     r_ql  [DivSteps];   // dividend bits out, quotient bits in
    logic [ValW-1:0]     r_den [DivSteps];
    logic [1:0]          r_reg [DivSteps];
    logic [ValW-1:0]     n_rem [DivSteps];
    logic [ValW-1:0]     n_ql  [DivSteps];

    always_comb begin
        en[DivSteps] = i_rdy;
        for (int i = DivSteps - 1; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end
    assign o_rdy = en[0];

    always_comb begin
        logic [ValW-1:0] s_rem, s_ql, s_den;
        logic [ValW:0]   t;
        logic            ge;
        for (int i = 0; i < DivSteps; i++) begin
            if (i == 0) begin
                s_rem = ValW'(i_word.num[NumW-1:ValW]);
                s_ql  = i_word.num[ValW-1:0];
                s_den = i_word.den;
            end else begin
                s_rem = r_rem[i-1];
                s_ql  = r_ql[i-1];
                s_den = r_den[i-1];
            end
            t  = {s_rem, s_ql[ValW-1]};
            ge = t >= {1'b0, s_den};
            if (ge) begin
                t = t - {1'b0, s_den};
            end
            n_rem[i] = t[ValW-1:0];
            n_ql[i]  = {s_ql[ValW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < DivSteps; i++) begin
                if (en[i]) begin
                    r_v[i] <= (i == 0) ? i_vld : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DivSteps; i++) begin
            if (en[i]) begin
                r_rem[i] <= n_rem[i];
                r_ql[i]  <= n_ql[i];
                r_den[i] <= (i == 0) ? i_word.den : r_den[i-1];
                r_reg[i] <= (i == 0) ? i_word.region : r_reg[i-1];
            end
        end
    end

    assign o_vld         = r_v[DivSteps-1];
    assign o_word.region = r_reg[DivSteps-1];
    assign o_word.val    = r_ql[DivSteps-1];
endmodule

// File: design/ptsd_sqrt.sv
// Integer square root, two radicand bits per register stage.
// Depends on ptsd_pkg.
module ptsd_sqrt import ptsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  t_root_word       i_word,
    output logic             o_vld,
    input  logic             i_rdy,
    output logic [RootW-1:0] o_root,
    output logic [1:0]       o_region
);
    logic [RootSteps-1:0] r_v;
    logic [RootSteps:0]   en;
    logic [RootW:0]       r_rem  [RootSteps];
    logic [RootW-1:0]     r_root [RootSteps];
    logic [ValW-1:0]      r_val  [RootSteps];
    logic [1:0]           r_reg  [RootSteps];
    logic [RootW:0]       n_rem  [RootSteps];
    logic [RootW-1:0]     n_root [RootSteps];

    always_comb begin
        en[RootSteps] = i_rdy;
        for (int i = RootSteps - 1; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end
    assign o_rdy = en[0];

    always_comb begin
        logic [RootW:0]   s_rem;
        logic [RootW-1:0] s_root;
        logic [ValW-1:0]  s_val;
        logic [RootW+2:0] t, trial;
        logic             ge;
        for (int i = 0; i < RootSteps; i++) begin
            if (i == 0) begin
                s_rem  = '0;
                s_root = '0;
                s_val  = i_word.val;
            end else begin
                s_rem  = r_rem[i-1];
                s_root = r_root[i-1];
                s_val  = r_val[i-1];
            end
            t     = {s_rem, s_val[ValW-1:ValW-2]};
            trial = {1'b0, s_root, 2'b01};
            ge    = t >= trial;
            if (ge) begin
                t = t - trial;
            end
            n_rem[i]  = t[RootW:0];
            n_root[i] = {s_root[RootW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < RootSteps; i++) begin
                if (en[i]) begin
                    r_v[i] <= (i == 0) ? i_vld : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RootSteps; i++) begin
            if (en[i]) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_val[i]  <= (i == 0) ? (i_word.val << 2) : (r_val[i-1] << 2);
                r_reg[i]  <= (i == 0) ? i_word.region : r_reg[i-1];
            end
        end
    end

    assign o_vld    = r_v[RootSteps-1];
    assign o_root   = r_root[RootSteps-1];
    assign o_region = r_reg[RootSteps-1];
endmodule

// File: design/point_to_segment_distance_top.sv
// Path from accepted input word to output word: 6 front stages, 34 divider stages,
// 17 root stages, 1 output register. Throughput: one word per cycle while the
// output is not stalled; every stage moves on when the next is free, so bubbles
// close up and a stalled output still lets upstream stages fill.
// Reset: synchronous, active low; clears all valid bits, data regs hold.
// Depends on ptsd_pkg, ptsd_front, ptsd_div and ptsd_sqrt.
module point_to_segment_distance_top import ptsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // point_x, point_y, start_x, start_y, end_x, end_y
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // distance, zero fill
    output logic [1:0]  o_m_tuser    // nearest_region
);
    localparam logic [DistW-1:0] MaxDist = DistW'(92682);

    t_coords          pts;
    t_div_word        div_word;
    t_root_word       root_word;
    logic             f_vld, f_rdy, d_vld, d_rdy, q_vld, q_rdy;
    logic [RootW-1:0] q_root;
    logic [1:0]       q_region;
    logic             r_ovld;
    logic [DistW-1:0] r_dist;
    logic [1:0]       r_region;

    assign pts = t_coords'(i_s_tdata);

    ptsd_front u_front (
        .i_clk, .i_rst_n,
        .i_vld (i_s_tvalid), .o_rdy (o_s_tready), .i_pts (pts),
        .o_vld (f_vld), .i_rdy (f_rdy), .o_word (div_word)
    );

    ptsd_div u_div (
        .i_clk, .i_rst_n,
        .i_vld (f_vld), .o_rdy (f_rdy), .i_word (div_word),
        .o_vld (d_vld), .i_rdy (d_rdy), .o_word (root_word)
    );

    ptsd_sqrt u_sqrt (
        .i_clk, .i_rst_n,
        .i_vld (d_vld), .o_rdy (d_rdy), .i_word (root_word),
        .o_vld (q_vld), .i_rdy (q_rdy), .o_root (q_root), .o_region (q_region)
    );

    assign q_rdy = !r_ovld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (q_rdy) begin
            r_ovld <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_rdy) begin
            r_dist   <= DistW'(q_root);
            r_region <= q_region;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {(24 - DistW)'(0), r_dist};
    assign o_m_tuser  = r_region;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid right after reset");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[DistW-1:0] <= MaxDist)
        else $error("distance beyond coordinate range");
    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == RegionStart || o_m_tuser == RegionInterior ||
                        o_m_tuser == RegionEnd))
        else $error("bad region code");
endmodule
